[rtl/ssp_pkg.sv]
// ---------------------------------------------------------------------------
// ssp_pkg: shared definitions of the size string parser
// Character codes, status codes, controller/datapath handshake structs and
// the power-of-ten table that supplies the fraction divisor.
// ---------------------------------------------------------------------------
package ssp_pkg;

    localparam int CH_W      = 8;
    localparam int STATUS_W  = 2;
    localparam int FRAC_W    = 5;
    localparam int SHIFT_W   = 5;
    localparam int DIVISOR_W = 64;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_LO_K  = 8'h6B;
    localparam logic [CH_W-1:0] CH_UP_K  = 8'h4B;
    localparam logic [CH_W-1:0] CH_LO_M  = 8'h6D;
    localparam logic [CH_W-1:0] CH_UP_M  = 8'h4D;
    localparam logic [CH_W-1:0] CH_LO_G  = 8'h67;
    localparam logic [CH_W-1:0] CH_UP_G  = 8'h47;

    localparam logic [SHIFT_W-1:0] SHIFT_NONE = 5'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_KILO = 5'd10;
    localparam logic [SHIFT_W-1:0] SHIFT_MEGA = 5'd20;
    localparam logic [SHIFT_W-1:0] SHIFT_GIGA = 5'd30;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // register the accepted byte
        logic step;     // apply the registered byte to the parse state
        logic load;     // move the finished result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic end_of_text;  // registered byte is the terminator
        logic div_done;     // fraction division has finished
    } sts_t;

    // Ten to the power of the fraction digit count.
    function automatic logic [DIVISOR_W-1:0] pow10(input logic [FRAC_W-1:0] n);
        logic [DIVISOR_W-1:0] r;
        unique case (n)
            5'd0:    r = 64'd1;
            5'd1:    r = 64'd10;
            5'd2:    r = 64'd100;
            5'd3:    r = 64'd1000;
            5'd4:    r = 64'd10000;
            5'd5:    r = 64'd100000;
            5'd6:    r = 64'd1000000;
            5'd7:    r = 64'd10000000;
            5'd8:    r = 64'd100000000;
            5'd9:    r = 64'd1000000000;
            5'd10:   r = 64'd10000000000;
            5'd11:   r = 64'd100000000000;
            5'd12:   r = 64'd1000000000000;
            5'd13:   r = 64'd10000000000000;
            5'd14:   r = 64'd100000000000000;
            5'd15:   r = 64'd1000000000000000;
            5'd16:   r = 64'd10000000000000000;
            5'd17:   r = 64'd100000000000000000;
            5'd18:   r = 64'd1000000000000000000;
            5'd19:   r = 64'd10000000000000000000;
            default: r = 64'd1;
        endcase
        return r;
    endfunction

endpackage

[rtl/ssp_div.sv]
// ---------------------------------------------------------------------------
// ssp_div: bit-serial restoring divider
// Produces one quotient bit per cycle; done pulses as the last bit is registered.
// ---------------------------------------------------------------------------
module ssp_div
    import ssp_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [DIVISOR_W-1:0]   divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DIVISOR_W-1:0]   rem_reg;
    logic [DIVISOR_W-1:0]   rem_next;
    logic [DIVISOR_W-1:0]   dvs_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] quo_next;
    logic [DIVISOR_W:0]     trial;
    logic [DIVISOR_W:0]     diff;
    logic                   fits;

    // The partial remainder stays below the divisor, so one extra bit holds
    // the shifted trial value.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VALUE_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/ssp_dp.sv]
// ---------------------------------------------------------------------------
// ssp_dp: size string parser datapath
// Holds the grammar phase, accumulator, fraction count and overflow flag,
// runs the fraction division and owns the output payload register.
// ---------------------------------------------------------------------------
module ssp_dp
    import ssp_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS = 19,
    parameter int VALUE_WIDTH         = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic [CH_W-1:0]        ch,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [STATUS_W-1:0]    status
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_INT,
        PH_FRAC,
        PH_TRAIL,
        PH_SUFFIX,
        PH_SKIP
    } phase_t;

    localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(MAX_FRACTION_DIGITS);

    logic [CH_W-1:0]        ch_reg;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic [FRAC_W-1:0]      frac_reg;
    logic [FRAC_W-1:0]      frac_next;
    logic [FRAC_W-1:0]      frac_inc;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic [STATUS_W-1:0]    fin_status_reg;
    logic [STATUS_W-1:0]    fin_status_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [STATUS_W-1:0]    status_reg;

    logic                   is_digit;
    logic                   is_space;
    logic                   is_nul;
    logic [3:0]             digit;
    logic [SHIFT_W-1:0]     sh_amt;
    logic [VALUE_WIDTH+3:0] prod;
    logic                   add_ovf;
    logic [VALUE_WIDTH+29:0] shifted;
    logic                   sh_ovf;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] quotient;

    // Byte classification.
    always_comb
    begin
        is_nul   = (ch_reg == CH_NUL);
        is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
        is_space = (ch_reg == CH_SPACE) || ((ch_reg >= CH_TAB) && (ch_reg <= CH_CR));
        digit    = 4'(ch_reg - CH_ZERO);
        priority if ((ch_reg == CH_LO_K) || (ch_reg == CH_UP_K))
            sh_amt = SHIFT_KILO;
        else if ((ch_reg == CH_LO_M) || (ch_reg == CH_UP_M))
            sh_amt = SHIFT_MEGA;
        else if ((ch_reg == CH_LO_G) || (ch_reg == CH_UP_G))
            sh_amt = SHIFT_GIGA;
        else
            sh_amt = SHIFT_NONE;
    end

    // Times ten as two shifted copies; anything above the value width overflows.
    always_comb
    begin
        prod    = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                + {{VALUE_WIDTH{1'b0}}, digit};
        add_ovf = |prod[VALUE_WIDTH+3:VALUE_WIDTH];
        shifted = {30'd0, acc_reg} << sh_amt;
        sh_ovf  = |shifted[VALUE_WIDTH+29:VALUE_WIDTH];
        frac_inc = (frac_reg <= FRAC_MAX) ? frac_reg + FRAC_W'(1) : frac_reg;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        frac_next       = frac_reg;
        ovf_next        = ovf_reg;
        fin_status_next = ST_OK;

        if (is_nul)
        begin
            if ((phase_reg == PH_LEAD) || (phase_reg == PH_SKIP))
                fin_status_next = ST_INVALID;
            else if (ovf_reg || (frac_reg > FRAC_MAX))
                fin_status_next = ST_OVERFLOW;
            else
                fin_status_next = ST_OK;
            phase_next = PH_LEAD;
            acc_next   = '0;
            frac_next  = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (is_digit)
                    begin
                        if (add_ovf)
                            ovf_next = 1'b1;
                        else
                            acc_next = prod[VALUE_WIDTH-1:0];
                        phase_next = PH_INT;
                    end
                    else if (!is_space)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_INT, PH_FRAC:
                begin
                    if (is_digit)
                    begin
                        if (!ovf_reg)
                        begin
                            if (add_ovf)
                                ovf_next = 1'b1;
                            else
                                acc_next = prod[VALUE_WIDTH-1:0];
                        end
                        if (phase_reg == PH_FRAC)
                        begin
                            frac_next = frac_inc;
                            if (frac_inc > FRAC_MAX)
                                ovf_next = 1'b1;
                        end
                    end
                    else if ((ch_reg == CH_POINT) && (phase_reg == PH_INT))
                    begin
                        phase_next = PH_FRAC;
                    end
                    else if (is_space)
                    begin
                        phase_next = PH_TRAIL;
                    end
                    else if (sh_amt != SHIFT_NONE)
                    begin
                        if (!ovf_reg)
                        begin
                            if (sh_ovf)
                                ovf_next = 1'b1;
                            else
                                acc_next = shifted[VALUE_WIDTH-1:0];
                        end
                        phase_next = PH_SUFFIX;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_TRAIL:
                begin
                    if (sh_amt != SHIFT_NONE)
                    begin
                        if (!ovf_reg)
                        begin
                            if (sh_ovf)
                                ovf_next = 1'b1;
                            else
                                acc_next = shifted[VALUE_WIDTH-1:0];
                        end
                        phase_next = PH_SUFFIX;
                    end
                    else if (!is_space)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            acc_reg   <= '0;
            frac_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            frac_reg  <= frac_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            ch_reg <= ch;
        if (div_start)
            fin_status_reg <= fin_status_next;
        if (cmd.load)
        begin
            value_reg  <= (fin_status_reg == ST_OK) ? quotient : '0;
            status_reg <= fin_status_reg;
        end
    end

    // The divider takes its own copy of the accumulator, so the parse state
    // clears at the terminator while the division runs.
    assign div_start = cmd.step && is_nul;

    ssp_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (pow10(frac_reg)),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sts.end_of_text = is_nul;
    assign sts.div_done    = div_done;
    assign value           = value_reg;
    assign status          = status_reg;

endmodule

[rtl/ssp_ctrl.sv]
// ---------------------------------------------------------------------------
// ssp_ctrl: size string parser controller
// Sequences byte capture, parse step, division wait and result hand-off.
// ---------------------------------------------------------------------------
module ssp_ctrl
    import ssp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic ch_valid,
    output logic ch_stall,
    output logic res_valid,
    input  logic res_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   slot_free;

    // The output register can take a new result when empty or being drained.
    assign slot_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.step    = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ch_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.step   = 1'b1;
                state_next = sts.end_of_text ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        res_valid_next = cmd.load || (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign ch_stall  = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

[rtl/size_string_parser.sv]
// ---------------------------------------------------------------------------
// size_string_parser: human-readable size text parser
// Takes a size text one byte per transfer and, at the NUL terminator, gives
// one result transfer with the scaled value and a status code.
// ---------------------------------------------------------------------------
// A byte is captured and then applied in a parse step, and the input stalls
// until the step is done; a NUL byte blocks the input further until the
// bit-serial divider (one quotient bit per cycle) has finished and its result
// has been loaded into the output register. Other bytes give no result.
// Reset (rst_n low, asynchronous) empties the output register and returns the
// parser to the leading whitespace phase with a cleared accumulator.
// ---------------------------------------------------------------------------
module size_string_parser
    import ssp_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS = 19,
    parameter int VALUE_WIDTH         = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Text byte channel.
    input  logic                   ch_valid,
    output logic                   ch_stall,
    input  logic [CH_W-1:0]        ch,
    // Result channel.
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [STATUS_W-1:0]    status
);

    // The controller owns the handshakes and the sequence of a byte: it
    // registers the byte, lets the datapath apply it in the next cycle and,
    // for the terminator, waits for the division before loading the output
    // register. The output register is separate from the parse state, so a
    // result may wait for its transfer while the next text is already parsed.
    cmd_t cmd;
    sts_t sts;

    ssp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch_valid  (ch_valid),
        .ch_stall  (ch_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the grammar phase, the accumulator (times ten plus
    // digit, overflow checked against VALUE_WIDTH bits), the suffix shift,
    // the fraction digit count and the divider that removes the fraction
    // scale by ten to the number of fraction digits.
    ssp_dp #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
        .VALUE_WIDTH         (VALUE_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .ch     (ch),
        .value  (value),
        .status (status)
    );

endmodule

[rtl/ssp_checker.sv]
// ---------------------------------------------------------------------------
// ssp_checker: port-level checks of the size string parser
// Watches the two channels of the top level and is bound to it below.
// ---------------------------------------------------------------------------
module ssp_checker
    import ssp_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   ch_valid,
    input logic                   ch_stall,
    input logic [CH_W-1:0]        ch,
    input logic                   res_valid,
    input logic                   res_stall,
    input logic [VALUE_WIDTH-1:0] value,
    input logic [STATUS_W-1:0]    status
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(value) && $stable(status))
        else $error("result payload changed while stalled");

    // Any result that is not ok carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != ST_OK) |-> (value == '0))
        else $error("non-ok result with nonzero value");

    // Each byte is followed by a cycle in which no byte is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid && !ch_stall |=> ch_stall)
        else $error("byte taken in the cycle after a byte");

    // A result never appears the cycle after a non-terminator byte arrives
    // with the output empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid && !ch_stall && (ch != CH_NUL) && !res_valid |=> !res_valid)
        else $error("result without a terminator");

endmodule

bind size_string_parser ssp_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_ssp_checker (.*);
